/* hdl/crc8cfc_pkg.sv */
// Package for the CRC-8 command frame checker.
// Holds the transfer payload types, status codes, frame constants and the CRC-8 byte update.
// No dependencies.
`timescale 1ns / 1ps

package crc8cfc_pkg;

    localparam int MAX_FRAME = 20;
    localparam int HDR_LEN   = 6;
    localparam int CNT_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    localparam logic [CNT_W-1:0] COUNT_MAX   = 9'd511;
    localparam logic [CNT_W-1:0] HDR_LEN_C   = CNT_W'(HDR_LEN);
    localparam logic [CNT_W-1:0] MIN_FRAME_C = CNT_W'(HDR_LEN + 1);
    localparam logic [CNT_W-1:0] MAX_FRAME_C = CNT_W'(MAX_FRAME);
    localparam logic [CNT_W-1:0] MAX_PL_C    = CNT_W'(MAX_FRAME - HDR_LEN - 1);

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_MSB  = 8'h80;
    localparam logic [7:0] ACK_FLAG = 8'h01;

    localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION = 1'b1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_FRAME   = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_BAD_LENGTH  = 3'd3,
        ST_BAD_CRC     = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } in_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] seq_number;
        logic [7:0] command_code;
        logic [7:0] flag_bits;
        logic [3:0] payload_length;
        logic       send_response;
    } out_t;

    // Everything the end-of-frame checks look at, as seen after the last byte.
    typedef struct packed {
        logic [CNT_W-1:0] byte_total;
        logic [7:0]       hdr_magic;
        logic [7:0]       hdr_version;
        logic [7:0]       hdr_seq;
        logic [7:0]       hdr_opcode;
        logic [7:0]       hdr_flags;
        logic [7:0]       hdr_length;
        logic [7:0]       crc_calc;
        logic [7:0]       crc_rx;
        logic [7:0]       magic;
        logic [7:0]       version;
    } eval_t;

    // Bitwise CRC-8, MSB first, no reflection and no final XOR.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 8'h00) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

/* hdl/crc8cfc_status.sv */
// End-of-frame checks of the CRC-8 command frame checker.
// Turns the collected header, length and CRC values into one result; uses crc8cfc_pkg.
`timescale 1ns / 1ps

module crc8cfc_status
    import crc8cfc_pkg::*;
(
    input  eval_t ev,
    output out_t  result
);

    logic [CNT_W-1:0] pl_ext;
    logic [CNT_W-1:0] full_len;
    status_t          status;

    assign pl_ext   = CNT_W'(ev.hdr_length);
    assign full_len = MIN_FRAME_C + pl_ext;

    always_comb begin
        if (ev.byte_total < MIN_FRAME_C || ev.byte_total > MAX_FRAME_C) begin
            status = ST_BAD_FRAME;
        end else if (ev.hdr_magic != ev.magic) begin
            status = ST_BAD_FRAME;
        end else if (ev.hdr_version != ev.version) begin
            status = ST_BAD_VERSION;
        end else if (pl_ext > MAX_PL_C) begin
            status = ST_BAD_LENGTH;
        end else if (ev.byte_total != full_len && ev.byte_total != MAX_FRAME_C) begin
            status = ST_BAD_LENGTH;
        end else if (ev.crc_calc != ev.crc_rx) begin
            status = ST_BAD_CRC;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        result.status = status;
        if (status == ST_OK) begin
            result.seq_number     = ev.hdr_seq;
            result.command_code   = ev.hdr_opcode;
            result.flag_bits      = ev.hdr_flags;
            result.payload_length = ev.hdr_length[3:0];
            result.send_response  = (ev.hdr_flags & ACK_FLAG) != 8'h00;
        end else begin
            result.seq_number     = 8'h00;
            result.command_code   = 8'h00;
            result.flag_bits      = 8'h00;
            result.payload_length = 4'h0;
            result.send_response  = 1'b1;
        end
    end

endmodule

/* hdl/crc8_command_frame_checker.sv */
// Top level of the CRC-8 command frame checker.
// Collects header, byte count and CRC per byte; uses crc8cfc_pkg and crc8cfc_status.
`timescale 1ns / 1ps

// One received byte is taken per transfer, one per clock cycle when the result side keeps up.
// The byte that carries frame_end produces one result, registered and shown on the cycle after
// that byte is taken; other bytes produce nothing. The single result register sets the rate:
// the input stalls only while a result is held and m_ready is low. The CRC-8 of a byte is a
// shallow XOR network computed combinationally. Registers are to be written by the user only while
// no frame is in progress; the block itself does not enforce this.
module crc8_command_frame_checker
    import crc8cfc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data
);

    logic [7:0]       magic_reg;
    logic [7:0]       version_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       crc_reg;
    logic [7:0]       crc_next;
    logic [7:0]       hdr_reg [HDR_LEN];
    logic [7:0]       hdr_next [HDR_LEN];
    logic [7:0]       rcrc_reg;
    logic [7:0]       rcrc_next;
    logic             m_valid_reg;
    out_t             m_data_reg;

    logic             accept;
    logic             in_hdr;
    logic             in_payload;
    logic             at_crc;
    logic [CNT_W-1:0] payload_end;
    eval_t            ev;
    out_t             result;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign payload_end = HDR_LEN_C + CNT_W'(hdr_reg[HDR_LEN-1]);
    assign in_hdr      = count_reg < HDR_LEN_C;
    assign in_payload  = !in_hdr && count_reg < payload_end;
    assign at_crc      = !in_hdr && count_reg == payload_end;

    always_comb begin
        for (int i = 0; i < HDR_LEN; i++) begin
            hdr_next[i] = hdr_reg[i];
        end
        if (in_hdr) begin
            hdr_next[count_reg[2:0]] = s_data.rx_byte;
        end
        crc_next   = (in_hdr || in_payload) ? crc8_byte(crc_reg, s_data.rx_byte) : crc_reg;
        rcrc_next  = at_crc ? s_data.rx_byte : rcrc_reg;
        count_next = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;
    end

    always_comb begin
        ev.byte_total  = count_next;
        ev.hdr_magic   = hdr_next[0];
        ev.hdr_version = hdr_next[1];
        ev.hdr_seq     = hdr_next[2];
        ev.hdr_opcode  = hdr_next[3];
        ev.hdr_flags   = hdr_next[4];
        ev.hdr_length  = hdr_next[5];
        ev.crc_calc    = crc_next;
        ev.crc_rx      = rcrc_next;
        ev.magic       = magic_reg;
        ev.version     = version_reg;
    end

    crc8cfc_status u_status (
        .ev     (ev),
        .result (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg   <= 8'h00;
            version_reg <= 8'h01;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MAGIC:   magic_reg   <= cfg_wdata;
                REG_VERSION: version_reg <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            crc_reg     <= 8'h00;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (s_data.frame_end) begin
                    count_reg <= '0;
                    crc_reg   <= 8'h00;
                end else begin
                    count_reg <= count_next;
                    crc_reg   <= crc_next;
                end
            end
            if (accept && s_data.frame_end) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < HDR_LEN; i++) begin
                hdr_reg[i] <= hdr_next[i];
            end
            rcrc_reg <= rcrc_next;
            if (s_data.frame_end) begin
                m_data_reg <= result;
            end
        end
    end

endmodule

/* hdl/crc8cfc_checker.sv */
// Port-level checker for the CRC-8 command frame checker, with its bind statement.
// Uses crc8cfc_pkg; attaches to crc8_command_frame_checker.
`timescale 1ns / 1ps

module crc8cfc_checker
    import crc8cfc_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or vanished while stalled");

    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.frame_end |=> m_valid)
        else $error("frame end transfer gave no result");

    a_error_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |->
            m_data.send_response && m_data.seq_number == 8'h00 &&
            m_data.command_code == 8'h00 && m_data.flag_bits == 8'h00 &&
            m_data.payload_length == 4'h0)
        else $error("error result carries header fields");

    a_ok_response: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_OK |->
            m_data.send_response == m_data.flag_bits[0] &&
            32'(m_data.payload_length) <= MAX_FRAME - HDR_LEN - 1)
        else $error("ok result with wrong response flag or length");

endmodule

bind crc8_command_frame_checker crc8cfc_checker u_crc8cfc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* tb/sv/crc8_command_frame_checker_test.sv */
// Self-checking testbench for crc8_command_frame_checker: drives byte streams of directed and
// random command frames under random idling, predicts every frame verdict and compares it.
// Depends on crc8cfc_pkg and the crc8_command_frame_checker RTL.
`timescale 1ns / 1ps

module crc8_command_frame_checker_test;
    import crc8cfc_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_t                  s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_t                 m_data;

    // Stimulus and expectations.
    in_t  rx_stream [$];
    out_t pending_verdicts [$];
    int unsigned bytes_queued = 0;

    // Configuration as the checker should see it.
    logic [7:0] cfg_magic   = 8'h00;
    logic [7:0] cfg_version = 8'h01;

    // Predicted frame state.
    logic [CNT_W-1:0] seen_count;
    logic [7:0]       calc_crc;
    logic [7:0]       hdr_bytes [HDR_LEN];
    logic [7:0]       crc_field;

    int  in_idle_pct   = 0;
    int  out_stall_pct = 0;
    bit  steady_tail   = 1'b0;
    int  in_gap        = 0;
    int  out_gap       = 0;
    int  quiet_cycles  = 0;
    int  mismatches    = 0;
    int  bytes_sent    = 0;
    int  verdicts_seen = 0;
    int  settings_used = 1;
    int  status_hits [5] = '{0, 0, 0, 0, 0};

    crc8_command_frame_checker DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ data[i];
            r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    // Advances the predicted frame state by one byte; returns 1 when the byte ends a frame.
    function automatic logic verdict_after_byte(input in_t item, output out_t res);
        int unsigned idx;
        int unsigned plen;
        status_t     st;
        idx = seen_count;
        res = '0;
        if (idx < HDR_LEN) begin
            hdr_bytes[idx] = item.rx_byte;
            calc_crc = crc8_next(calc_crc, item.rx_byte);
        end else if (idx < HDR_LEN + hdr_bytes[5]) begin
            calc_crc = crc8_next(calc_crc, item.rx_byte);
        end else if (idx == HDR_LEN + hdr_bytes[5]) begin
            crc_field = item.rx_byte;
        end
        if (seen_count != COUNT_MAX) begin
            seen_count = seen_count + 1'b1;
        end
        if (!item.frame_end) begin
            return 1'b0;
        end
        plen = hdr_bytes[5];
        if (seen_count < HDR_LEN + 1 || seen_count > MAX_FRAME) begin
            st = ST_BAD_FRAME;
        end else if (hdr_bytes[0] != cfg_magic) begin
            st = ST_BAD_FRAME;
        end else if (hdr_bytes[1] != cfg_version) begin
            st = ST_BAD_VERSION;
        end else if (plen > MAX_FRAME - HDR_LEN - 1) begin
            st = ST_BAD_LENGTH;
        end else if (seen_count != HDR_LEN + plen + 1 && seen_count != MAX_FRAME) begin
            st = ST_BAD_LENGTH;
        end else if (calc_crc != crc_field) begin
            st = ST_BAD_CRC;
        end else begin
            st = ST_OK;
        end
        res.status = st;
        if (st == ST_OK) begin
            res.seq_number     = hdr_bytes[2];
            res.command_code   = hdr_bytes[3];
            res.flag_bits      = hdr_bytes[4];
            res.payload_length = hdr_bytes[5][3:0];
            res.send_response  = (hdr_bytes[4] & ACK_FLAG) != 8'h00;
        end else begin
            res.send_response  = 1'b1;
        end
        seen_count = '0;
        calc_crc   = 8'h00;
        return 1'b1;
    endfunction

    task automatic cmp_field(input string field, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Driver: one byte per transfer, with random idle bursts between bytes.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            in_gap  <= 0;
        end else if (!s_valid || s_ready) begin
            if (in_gap > 0) begin
                s_valid <= 1'b0;
                in_gap  <= in_gap - 1;
            end else if (rx_stream.size() != 0) begin
                s_data  <= rx_stream.pop_front();
                s_valid <= 1'b1;
                if (!steady_tail && $urandom_range(99) < in_idle_pct) begin
                    in_gap <= $urandom_range(17, 1);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: predicts on every byte transfer, checks every verdict transfer, stalls m_ready.
    always @(posedge aclk) begin
        out_t want;
        out_t next_verdict;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            out_gap    <= 0;
            seen_count = '0;
            calc_crc   = 8'h00;
            crc_field  = 8'h00;
            for (int i = 0; i < HDR_LEN; i++) begin
                hdr_bytes[i] = 8'h00;
            end
        end else begin
            if (s_valid && s_ready) begin
                bytes_sent++;
                if (verdict_after_byte(s_data, next_verdict)) begin
                    pending_verdicts.push_back(next_verdict);
                end
            end
            if (m_valid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: unexpected verdict, expected none, actual %h", $time, m_data);
                    mismatches++;
                end else begin
                    want = pending_verdicts.pop_front();
                    verdicts_seen++;
                    status_hits[int'(want.status)]++;
                    cmp_field("status", want.status, m_data.status);
                    cmp_field("seq_number", want.seq_number, m_data.seq_number);
                    cmp_field("command_code", want.command_code, m_data.command_code);
                    cmp_field("flag_bits", want.flag_bits, m_data.flag_bits);
                    cmp_field("payload_length", want.payload_length, m_data.payload_length);
                    cmp_field("send_response", want.send_response, m_data.send_response);
                end
            end
            if (out_gap > 0) begin
                m_ready <= 1'b0;
                out_gap <= out_gap - 1;
            end else if (!steady_tail && $urandom_range(99) < out_stall_pct) begin
                m_ready <= 1'b0;
                out_gap <= $urandom_range(17, 1) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles at %0t", quiet_cycles, $time);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Builds one frame of the given length. The CRC byte sits right after the declared payload
    // and covers every earlier byte; bytes past it are random padding.
    task automatic add_frame(input logic [7:0] magic, input logic [7:0] ver,
                             input logic [7:0] seq, input logic [7:0] opcode,
                             input logic [7:0] flags, input logic [7:0] plen,
                             input int total, input bit crc_good);
        logic [7:0] hdr [HDR_LEN];
        logic [7:0] crc;
        logic [7:0] b;
        in_t        item;
        hdr = '{magic, ver, seq, opcode, flags, plen};
        crc = 8'h00;
        for (int i = 0; i < total; i++) begin
            if (i < HDR_LEN) begin
                b = hdr[i];
            end else if (i == HDR_LEN + plen) begin
                b = crc_good ? crc : crc ^ 8'($urandom_range(255, 1));
            end else begin
                b = 8'($urandom_range(255));
            end
            if (i < HDR_LEN + plen) begin
                crc = crc8_next(crc, b);
            end
            item.rx_byte   = b;
            item.frame_end = (i == total - 1);
            rx_stream.push_back(item);
        end
        bytes_queued += total;
    endtask

    task automatic add_noise(input int n);
        in_t item;
        for (int i = 0; i < n; i++) begin
            item.rx_byte   = 8'($urandom_range(255));
            item.frame_end = (i == n - 1) || ($urandom_range(5) == 0);
            rx_stream.push_back(item);
        end
        bytes_queued += n;
    endtask

    task automatic add_random_frame();
        int unsigned pick;
        int unsigned pl;
        int unsigned total;
        logic [7:0]  m;
        logic [7:0]  v;
        bit          crc_good;
        pick     = $urandom_range(99);
        pl       = $urandom_range(MAX_FRAME - HDR_LEN - 1);
        total    = HDR_LEN + 1 + pl;
        m        = cfg_magic;
        v        = cfg_version;
        crc_good = 1'b1;
        if (pick < 40) begin
            total = HDR_LEN + 1 + pl;
        end else if (pick < 55) begin
            pl    = $urandom_range(MAX_FRAME - HDR_LEN - 2);
            total = MAX_FRAME;
        end else if (pick < 65) begin
            crc_good = 1'b0;
            if ($urandom_range(1) == 1) begin
                total = MAX_FRAME;
            end
        end else if (pick < 72) begin
            m = m ^ 8'($urandom_range(255, 1));
        end else if (pick < 79) begin
            v = v ^ 8'($urandom_range(255, 1));
        end else if (pick < 85) begin
            pl    = $urandom_range(255, MAX_FRAME - HDR_LEN);
            total = $urandom_range(MAX_FRAME, HDR_LEN + 1);
        end else if (pick < 91) begin
            do begin
                total = $urandom_range(MAX_FRAME - 1, HDR_LEN + 1);
            end while (total == HDR_LEN + 1 + pl);
        end else if (pick < 95) begin
            total = $urandom_range(HDR_LEN, 1);
        end else if (pick < 98) begin
            total = $urandom_range(40, MAX_FRAME + 1);
        end else begin
            add_noise($urandom_range(12, 1));
            return;
        end
        add_frame(m, v, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'(pl), total, crc_good);
    endtask

    function automatic int idle_choice();
        case ($urandom_range(3))
            0: return 0;
            1: return 10;
            2: return 35;
            default: return 70;
        endcase
    endfunction

    task automatic drain_and_settle();
        while (rx_stream.size() != 0 || s_valid || pending_verdicts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [7:0] magic, input logic [7:0] ver);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAGIC;
        cfg_wdata <= magic;
        @(posedge aclk);
        cfg_index <= REG_VERSION;
        cfg_wdata <= ver;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_magic   = magic;
        cfg_version = ver;
        settings_used++;
    endtask

    initial begin
        logic [7:0]  magic;
        logic [7:0]  ver;
        int unsigned phase_start;
        int unsigned seg_start;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        in_idle_pct   = 20;
        out_stall_pct = 20;
        add_frame(8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'd0, 7, 1'b1);
        add_frame(8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'd13, MAX_FRAME, 1'b1);
        add_frame(8'h00, 8'h01, 8'h12, 8'h34, 8'h01, 8'd2, MAX_FRAME, 1'b1);
        add_frame(8'h00, 8'h01, 8'h55, 8'hAA, 8'h00, 8'd3, 10, 1'b0);
        add_frame(8'h80, 8'h01, 8'h01, 8'h02, 8'h00, 8'd1, 8, 1'b1);
        add_frame(8'h00, 8'hFE, 8'h01, 8'h02, 8'h01, 8'd1, 8, 1'b1);
        add_frame(8'h80, 8'hFE, 8'h01, 8'h02, 8'h01, 8'd1, 8, 1'b1);
        add_frame(8'h00, 8'h01, 8'h07, 8'h08, 8'h00, 8'd14, MAX_FRAME, 1'b1);
        add_frame(8'h00, 8'h01, 8'h07, 8'h08, 8'h00, 8'hFF, 8, 1'b1);
        add_frame(8'h00, 8'h01, 8'h07, 8'h08, 8'h00, 8'd5, 9, 1'b1);
        add_frame(8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'd0, 1, 1'b1);
        add_frame(8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'd0, HDR_LEN, 1'b1);
        add_frame(8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'd0, MAX_FRAME + 1, 1'b1);
        add_frame(8'h00, 8'h01, 8'h3C, 8'hC3, 8'h01, 8'd4, MAX_FRAME, 1'b0);
        drain_and_settle();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin magic = 8'hFF; ver = 8'h00; end
                1: begin magic = 8'h00; ver = 8'hFF; end
                default: begin
                    magic = 8'($urandom_range(255));
                    ver   = 8'($urandom_range(255));
                end
            endcase
            write_regs(magic, ver);
            steady_tail = (ph == 4);
            if (ph == 2) begin
                // Long enough to saturate the byte counter.
                add_frame(cfg_magic, cfg_version, 8'h11, 8'h22, 8'h00, 8'd0, 519, 1'b1);
            end
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < 120) begin
                in_idle_pct   = idle_choice();
                out_stall_pct = idle_choice();
                seg_start     = bytes_queued;
                while (bytes_queued - seg_start < 60) begin
                    add_random_frame();
                end
                while (rx_stream.size() != 0) begin
                    @(posedge aclk);
                end
            end
            drain_and_settle();
        end

        $display("Covered %0d input bytes under %0d register settings, %0d verdicts checked.",
                 bytes_sent, settings_used, verdicts_seen);
        $display("Verdicts: ok %0d, bad frame %0d, bad version %0d, bad length %0d, bad crc %0d.",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
